FILE: rtl/core/fit_policy_block_allocator_macros.svh
// assertion macros for the fit policy block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define FPBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpba check failed");

// next-cycle implication, disabled during reset
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpba check failed");

`else

`define FPBA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/fpba_pkg.sv
// shared types and codes of the fit policy block allocator
package fpba_pkg;

  // input function codes
  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_REQUEST = 2'd1,
    FUNC_RESTORE = 2'd2
  } func_t;

  // placement rules
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2
  } fit_mode_t;

  // configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic       load;
    logic       restore;
    logic       sub;
    logic [1:0] mode;
  } cmd_t;

endpackage

FILE: rtl/core/fpba_cell.sv
// one block cell: capacity and original size plus one stage of the search token
module fpba_cell #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int INDEX      = 0,
  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
  localparam int UW = $clog2(NUM_BLOCKS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fpba_pkg::cmd_t       cmd,
  input  logic [IW-1:0]        sel,
  input  logic [SIZE_BITS-1:0] wr_data,
  input  logic [SIZE_BITS-1:0] req_amt,
  input  logic [UW-1:0]        used,
  input  logic                 tok_in_valid,
  input  logic                 tok_in_found,
  input  logic [IW-1:0]        tok_in_pick,
  input  logic [SIZE_BITS-1:0] tok_in_best,
  output logic                 tok_out_valid,
  output logic                 tok_out_found,
  output logic [IW-1:0]        tok_out_pick,
  output logic [SIZE_BITS-1:0] tok_out_best
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] cap;
  logic [SIZE_BITS-1:0] orig;
  logic                 hit;
  logic                 active;
  logic                 fits;
  logic                 better;
  logic                 take;

  assign hit    = (sel == IW'(INDEX));
  assign active = (UW'(INDEX) < used);

  // block tables: load, restore and write-back
  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      cap  <= wr_data;
      orig <= wr_data;
    end else if (cmd.restore) begin
      cap <= orig;
    end else if (cmd.sub && hit) begin
      cap <= cap - wr_data;
    end
  end

  // placement decision for this block
  always_comb begin
    fits   = active && (cap >= req_amt) &&
             (cmd.mode == MODE_FIRST || cmd.mode == MODE_BEST || cmd.mode == MODE_WORST);
    better = (cmd.mode == MODE_BEST  && cap < tok_in_best) ||
             (cmd.mode == MODE_WORST && cap > tok_in_best);
    take   = tok_in_valid && fits && (!tok_in_found || better);
  end

  // token stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  // token stage payload
  always_ff @(posedge clk) begin
    tok_out_found <= tok_in_found || take;
    tok_out_pick  <= take ? IW'(INDEX) : tok_in_pick;
    tok_out_best  <= take ? cap : tok_in_best;
  end

endmodule

FILE: rtl/core/fit_policy_block_allocator.sv
// Fit policy block allocator: a search token walks a chain of block cells, one cell a cycle.
// Request: accepted, then the token passes through the NUM_BLOCKS cells and a write-back/result step
// follows; the result is then loaded into the output register once it is free and offered from there.
// Load, restore and unused codes take effect at the transfer; their result then goes to the output register.
// One item in work at a time: a new item is taken only after the last result has been loaded.
// Synchronous reset clears the controller, configuration and valid registers; block tables are undefined until loaded.
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  block_slot,
  input  logic [15:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [3:0]  chosen_block,
  output logic [15:0] left_over
);
  import fpba_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int UW = $clog2(NUM_BLOCKS + 1);

  state_t               state;
  state_t               state_next;
  logic [1:0]           fit_mode;
  logic [4:0]           block_count;
  logic [UW-1:0]        used;
  logic [SIZE_BITS-1:0] req_amt;
  logic [SIZE_BITS-1:0] in_amt;
  logic [IW-1:0]        slot_idx;
  logic                 slot_ok;
  logic                 in_acc;
  logic                 launch;
  logic                 out_load;
  cmd_t                 cmd;
  logic [IW-1:0]        sel;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 res_granted;
  logic [3:0]           res_block;
  logic [15:0]          res_left;

  logic                 tok_valid [0:NUM_BLOCKS];
  logic                 tok_found [0:NUM_BLOCKS];
  logic [IW-1:0]        tok_pick  [0:NUM_BLOCKS];
  logic [SIZE_BITS-1:0] tok_best  [0:NUM_BLOCKS];
  logic                 end_valid;
  logic                 end_found;
  logic [IW-1:0]        end_pick;
  logic [SIZE_BITS-1:0] end_best;

  assign end_valid = tok_valid[NUM_BLOCKS];
  assign end_found = tok_found[NUM_BLOCKS];
  assign end_pick  = tok_pick[NUM_BLOCKS];
  assign end_best  = tok_best[NUM_BLOCKS];

  // input decode
  assign in_amt   = SIZE_BITS'(amount);
  assign slot_idx = IW'(block_slot);
  assign slot_ok  = (32'(block_slot) < NUM_BLOCKS);
  assign used     = (32'(block_count) > NUM_BLOCKS) ? UW'(NUM_BLOCKS) : UW'(block_count);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= 2'd0;
      block_count <= 5'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIT_MODE:    fit_mode    <= cfg_data[1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data;
        default:         ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_REQUEST) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (end_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready    = (state == ST_IDLE);
    in_acc      = in_ready && in_valid;
    launch      = in_acc && (func == FUNC_REQUEST);
    out_load    = (state == ST_FINISH) && (!out_valid || out_ready);
    cmd.load    = in_acc && (func == FUNC_LOAD) && slot_ok;
    cmd.restore = in_acc && (func == FUNC_RESTORE);
    cmd.sub     = (state == ST_SCAN) && end_valid && end_found;
    cmd.mode    = fit_mode;
    sel         = cmd.sub ? end_pick : slot_idx;
    wr_data     = cmd.sub ? req_amt : in_amt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // token launch into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid[0] <= 1'b0;
    end else begin
      tok_valid[0] <= launch;
    end
  end

  assign tok_found[0] = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_best[0]  = '0;

  // request size held for the scan
  always_ff @(posedge clk) begin
    if (launch) begin
      req_amt <= in_amt;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (in_acc && func != FUNC_REQUEST) begin
      res_granted <= 1'b0;
      res_block   <= 4'd0;
      res_left    <= 16'd0;
    end else if (state == ST_SCAN && end_valid) begin
      res_granted <= end_found;
      res_block   <= end_found ? 4'(end_pick) : 4'd0;
      res_left    <= end_found ? 16'(end_best - req_amt) : 16'd0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      granted      <= res_granted;
      chosen_block <= res_block;
      left_over    <= res_left;
    end
  end

  // chain of block cells
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .sel           (sel),
      .wr_data       (wr_data),
      .req_amt       (req_amt),
      .used          (used),
      .tok_in_valid  (tok_valid[i]),
      .tok_in_found  (tok_found[i]),
      .tok_in_pick   (tok_pick[i]),
      .tok_in_best   (tok_best[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out_found (tok_found[i+1]),
      .tok_out_pick  (tok_pick[i+1]),
      .tok_out_best  (tok_best[i+1])
    );
  end

  // checks
  `include "fit_policy_block_allocator_macros.svh"

  `FPBA_ASSERT_NOW(a_token_only_in_scan, clk, rst, end_valid, state == ST_SCAN)
  `FPBA_ASSERT_NOW(a_pick_in_use, clk, rst, cmd.sub, 32'(end_pick) < 32'(used))
  `FPBA_ASSERT_NEXT(a_request_scans, clk, rst, launch, state == ST_SCAN && !in_ready)

endmodule

FILE: test/fit_policy_block_allocator_test.sv
// self-checking testbench for the fit policy block allocator
module fit_policy_block_allocator_test;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 41;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one allocation outcome as seen on the result channel
  typedef struct packed {
    logic        granted;
    logic [3:0]  block;
    logic [15:0] rest;
  } grant_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [3:0]  block_slot = '0;
  logic [15:0] amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        granted;
  logic [3:0]  chosen_block;
  logic [15:0] left_over;

  // shadow copy of the block tables and registers
  logic [15:0] free_left [NUM_BLOCKS];
  logic [15:0] loaded_size [NUM_BLOCKS];
  logic [1:0]  mode_reg = MODE_FIRST;
  logic [4:0]  count_reg = '0;

  grant_t expected_grants[$];
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  int     hold_len = 0;
  bit     in_gaps_on = 1'b1;
  bit     out_gaps_on = 1'b1;

  fit_policy_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (16)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .block_slot  (block_slot),
    .amount      (amount),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .granted     (granted),
    .chosen_block(chosen_block),
    .left_over   (left_over)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one item to the shadow tables and work out its outcome
  function automatic grant_t predict_alloc(logic [1:0] f, logic [3:0] slot, logic [15:0] amt);
    grant_t r;
    int     used;
    int     j;
    int     pick;
    bit     found;
    r = '0;
    found = 1'b0;
    pick = 0;
    used = (count_reg > NUM_BLOCKS) ? NUM_BLOCKS : count_reg;
    case (f)
      FUNC_LOAD: begin
        free_left[slot] = amt;
        loaded_size[slot] = amt;
      end
      FUNC_RESTORE: begin
        free_left = loaded_size;
      end
      FUNC_REQUEST: begin
        if (mode_reg != MODE_UNUSED) begin
          for (j = 0; j < used; j++) begin
            if (free_left[j] < amt) continue;
            if (!found) begin
              found = 1'b1;
              pick = j;
              if (mode_reg == MODE_FIRST) break;
            end else if (mode_reg == MODE_BEST && free_left[j] < free_left[pick]) begin
              pick = j;
            end else if (mode_reg == MODE_WORST && free_left[j] > free_left[pick]) begin
              pick = j;
            end
          end
          if (found) begin
            free_left[pick] = free_left[pick] - amt;
            r.granted = 1'b1;
            r.block = pick[3:0];
            r.rest = free_left[pick];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one item after a random gap and log its outcome on transfer
  task automatic send_item(input logic [1:0] f, input logic [3:0] s, input logic [15:0] a);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    block_slot <= s;
    amount <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_grants.push_back(predict_alloc(f, s, a));
  endtask

  // let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write, then the write port goes idle before the task returns
  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_FIT_MODE) mode_reg = val[1:0];
    else count_reg = val;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // change placement rule and block count while the block is idle
  task automatic set_policy(input logic [1:0] mode, input logic [4:0] count);
    drain_results();
    write_reg(CFG_FIT_MODE, {3'b000, mode});
    write_reg(CFG_BLOCK_COUNT, count);
  endtask

  // request sizes biased toward the current capacities
  function automatic logic [15:0] pick_amount();
    logic [15:0] cap;
    cap = free_left[$urandom_range(0, NUM_BLOCKS - 1)];
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom());
      4, 5: return cap;
      6: return cap - 16'($urandom_range(0, 3));
      7: return cap + 16'd1;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_item();
    int pct;
    pct = $urandom_range(0, 99);
    if (pct < 3) begin
      send_item(FUNC_UNUSED, 4'($urandom()), 16'($urandom()));
    end else if (pct < 8) begin
      send_item(FUNC_RESTORE, 4'($urandom()), 16'($urandom()));
    end else if (pct < 22) begin
      send_item(FUNC_LOAD, 4'($urandom()),
                $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 1023)));
    end else begin
      send_item(FUNC_REQUEST, 4'($urandom()), pick_amount());
    end
  endtask

  // requests against an empty block list
  task automatic test_empty_table();
    send_item(FUNC_REQUEST, 4'h0, 16'h0000);
    send_item(FUNC_REQUEST, 4'hF, 16'hFFFF);
  endtask

  // loads, including one outside the blocks in use
  task automatic test_load_blocks();
    send_item(FUNC_LOAD, 4'd0, 16'd100);
    send_item(FUNC_LOAD, 4'd1, 16'd40);
    send_item(FUNC_LOAD, 4'd2, 16'hFFFF);
    send_item(FUNC_LOAD, 4'd3, 16'd40);
    send_item(FUNC_LOAD, 4'd15, 16'h0000);
  endtask

  task automatic test_first_fit();
    set_policy(MODE_FIRST, 5'd4);
    send_item(FUNC_REQUEST, 4'd0, 16'd40);
    send_item(FUNC_REQUEST, 4'd0, 16'd0);
    send_item(FUNC_REQUEST, 4'd0, 16'd61);
  endtask

  // tie between equal blocks goes to the lower index
  task automatic test_best_fit();
    set_policy(MODE_BEST, 5'd4);
    send_item(FUNC_REQUEST, 4'd0, 16'd40);
    send_item(FUNC_REQUEST, 4'd0, 16'd60);
  endtask

  task automatic test_worst_fit();
    set_policy(MODE_WORST, 5'd4);
    send_item(FUNC_REQUEST, 4'd0, 16'd1);
    send_item(FUNC_REQUEST, 4'd0, 16'hFFFF);
  endtask

  // unused placement rule and unused function code
  task automatic test_unused_codes();
    set_policy(MODE_UNUSED, 5'd4);
    send_item(FUNC_REQUEST, 4'd0, 16'd0);
    send_item(FUNC_UNUSED, 4'hF, 16'hFFFF);
  endtask

  task automatic test_restore();
    set_policy(MODE_FIRST, 5'd4);
    send_item(FUNC_RESTORE, 4'd0, 16'd0);
    send_item(FUNC_REQUEST, 4'd0, 16'hFFFF);
  endtask

  // fill every block, then run mixed traffic under many register settings
  task automatic test_random_traffic();
    int          p;
    int          k;
    logic [1:0]  mode;
    logic [4:0]  count;
    in_gaps_on = 1'b1;
    for (k = 0; k < NUM_BLOCKS; k++) send_item(FUNC_LOAD, k[3:0], 16'($urandom()));
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin mode = MODE_FIRST; count = 5'd16; end
        1: begin mode = MODE_BEST; count = 5'd16; end
        2: begin mode = MODE_WORST; count = 5'd16; end
        3: begin mode = MODE_FIRST; count = 5'd1; end
        4: begin mode = MODE_BEST; count = 5'd31; end
        5: begin mode = MODE_WORST; count = 5'd0; end
        6: begin mode = MODE_UNUSED; count = 5'd16; end
        7: begin mode = MODE_BEST; count = 5'd8; end
        default: begin
          mode = 2'($urandom_range(0, 2));
          count = $urandom_range(0, 3) == 0 ? 5'($urandom()) : 5'($urandom_range(1, 16));
        end
      endcase
      set_policy(mode, count);
      in_gaps_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_gaps_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
    end
  endtask

  // receiver holds off while items keep coming
  task automatic test_output_hold();
    int k;
    set_policy(MODE_BEST, 5'd16);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b1;
    hold_len = HOLD_CYCLES;
    for (k = 0; k < 30; k++) random_item();
    in_gaps_on = 1'b1;
  endtask

  // result receiver with random stalls
  initial begin : result_sink
    int wait_len;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_len > 0) begin
        wait_len = hold_len;
        hold_len = 0;
      end else begin
        wait_len = out_gaps_on ? $urandom_range(0, 16) : 0;
      end
      if (wait_len > 0) begin
        out_ready <= 1'b0;
        repeat (wait_len) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest outcome waiting
  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: granted=%0b block=%0d left_over=%0d",
                   granted, chosen_block, left_over);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        if (granted !== want.granted || chosen_block !== want.block ||
            left_over !== want.rest) begin
          if (mismatch_count < 10)
            $display("mismatch (exp/act): granted %0b/%0b block %0d/%0d left_over %0d/%0d",
                     want.granted, granted, want.block, chosen_block, want.rest, left_over);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fit_policy_block_allocator_test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_load_blocks();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_unused_codes();
    test_restore();
    test_random_traffic();
    test_output_hold();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_grants.size() != 0) begin
      $display("%0d expected results never arrived", expected_grants.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("fit_policy_block_allocator_test passed");
    end else begin
      $display("fit_policy_block_allocator_test failed");
    end
    $finish;
  end

endmodule

FILE: fit_policy_block_allocator.f
+incdir+rtl/core
rtl/core/fpba_pkg.sv
rtl/core/fpba_cell.sv
rtl/core/fit_policy_block_allocator.sv
test/fit_policy_block_allocator_test.sv
